// ----- hw/rtl/fdasc_pkg.sv -----
// Package for the fixed-point to decimal text converter.
// Item types, character codes, microcode word layout and a power-of-ten table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fdasc_pkg;

   localparam int INT_LIMIT_DEFAULT = 9999;
   localparam int MAX_FRAC_DEFAULT  = 5;
   localparam int FRAC_BITS_DEFAULT = 16;

   // integer part after saturation fits 15 bits, at most five decimal digits
   localparam int INT_W     = 15;
   localparam int POW_W     = 17;
   localparam int TOP_POWER = 4;

   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_POINT = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;

   typedef struct packed {
      logic signed [31:0] value_fixed;
      logic [2:0]         frac_digits;
   } in_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
      logic [3:0] text_length;
   } out_type;

   // datapath operations
   localparam logic [2:0] OP_NOP   = 3'd0;
   localparam logic [2:0] OP_SIGN  = 3'd1;
   localparam logic [2:0] OP_INT   = 3'd2;
   localparam logic [2:0] OP_POINT = 3'd3;
   localparam logic [2:0] OP_FRAC  = 3'd4;

   // sequencer branch conditions
   localparam logic [2:0] COND_WAIT      = 3'd0;
   localparam logic [2:0] COND_NEXT      = 3'd1;
   localparam logic [2:0] COND_LOOP_INT  = 3'd2;
   localparam logic [2:0] COND_SKIP_FRAC = 3'd3;
   localparam logic [2:0] COND_LOOP_FRAC = 3'd4;

   typedef struct packed {
      logic [2:0] op;
      logic [2:0] cond;
      logic [2:0] target;
   } ctrl_type;

   typedef struct packed {
      logic accept;
      logic int_more;
      logic frac_zero;
      logic frac_more;
   } flags_type;

   function automatic logic [POW_W-1:0] pow10(input logic [2:0] k);
      logic [POW_W-1:0] p;
      begin
         case (k)
            3'd0: p = 17'd1;
            3'd1: p = 17'd10;
            3'd2: p = 17'd100;
            3'd3: p = 17'd1000;
            3'd4: p = 17'd10000;
            default: p = 17'd0;
         endcase
         return p;
      end
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/fdasc_seq.sv -----
// Microcode sequencer: control store, step counter and branch logic.
// Depends on fdasc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdasc_seq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire fdasc_pkg::flags_type flags,
   output fdasc_pkg::ctrl_type     ctrl,
   output logic                    busy
);

   localparam logic [2:0] STEP_IDLE  = 3'd0;
   localparam logic [2:0] STEP_SIGN  = 3'd1;
   localparam logic [2:0] STEP_INT   = 3'd2;
   localparam logic [2:0] STEP_POINT = 3'd3;
   localparam logic [2:0] STEP_FRAC  = 3'd4;

   logic [2:0] step_ff, step_in;

   function automatic fdasc_pkg::ctrl_type rom(input logic [2:0] s);
      fdasc_pkg::ctrl_type w;
      begin
         case (s)
            STEP_IDLE:  w = '{fdasc_pkg::OP_NOP,   fdasc_pkg::COND_WAIT,      STEP_IDLE};
            STEP_SIGN:  w = '{fdasc_pkg::OP_SIGN,  fdasc_pkg::COND_NEXT,      STEP_IDLE};
            STEP_INT:   w = '{fdasc_pkg::OP_INT,   fdasc_pkg::COND_LOOP_INT,  STEP_IDLE};
            STEP_POINT: w = '{fdasc_pkg::OP_POINT, fdasc_pkg::COND_SKIP_FRAC, STEP_IDLE};
            STEP_FRAC:  w = '{fdasc_pkg::OP_FRAC,  fdasc_pkg::COND_LOOP_FRAC, STEP_IDLE};
            default:    w = '{fdasc_pkg::OP_NOP,   fdasc_pkg::COND_NEXT,      STEP_IDLE};
         endcase
         return w;
      end
   endfunction

   assign ctrl = rom(step_ff);
   assign busy = (step_ff != STEP_IDLE);

   always_comb begin
      case (ctrl.cond)
         fdasc_pkg::COND_WAIT:      step_in = flags.accept ? step_ff + 3'd1 : step_ff;
         fdasc_pkg::COND_NEXT:      step_in = ctrl.target == STEP_IDLE && step_ff > STEP_FRAC ?
                                              STEP_IDLE : step_ff + 3'd1;
         fdasc_pkg::COND_LOOP_INT:  step_in = flags.int_more ? step_ff : step_ff + 3'd1;
         fdasc_pkg::COND_SKIP_FRAC: step_in = flags.frac_zero ? ctrl.target : step_ff + 3'd1;
         fdasc_pkg::COND_LOOP_FRAC: step_in = flags.frac_more ? step_ff : ctrl.target;
         default:                   step_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   a_loop_int_stays: assert property (@(posedge clock) disable iff (reset)
      step_ff == STEP_INT && flags.int_more |=> step_ff == STEP_INT)
      else $error("int digit loop left early");
   a_idle_waits: assert property (@(posedge clock) disable iff (reset)
      step_ff == STEP_IDLE && !flags.accept |=> step_ff == STEP_IDLE)
      else $error("sequencer left idle without an item");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_FRAC)
      else $error("step counter out of program");

endmodule

`default_nettype wire

// ----- hw/rtl/fixed_to_decimal_ascii.sv -----
// Top level: converts a signed fixed-point number into decimal ASCII text.
// Holds the digit datapath; fdasc_seq runs the microcode. Depends on fdasc_pkg.
//
// Usage: drive req_item and raise start; the item is taken at a clock edge
// where start is high and busy is low. The text leaves on rsp_item one
// character per rsp_strobe pulse: optional '-', integer digits without
// leading zeros (saturated at INT_LIMIT), then '.' and the truncated fraction
// digits when frac_digits is nonzero (clamped to MAX_FRAC). The final
// character has last_char set and text_length holding the character count.
// For a negative number the first character is the minus sign from the sign
// step; otherwise it comes from the first integer step that finds a nonzero
// digit, or from the units position.
// An item occupies the sequencer for 1 sign step, 5 integer-digit steps (one
// per decimal position, leading zeros dropped), 1 point step and one step per
// fraction digit; the sequencer then returns to idle, where the next item is
// taken. Each integer digit is one compare bank against the multiples of a
// power of ten; each fraction digit is one multiply by ten. Results cannot be
// stalled: each strobe lasts one cycle.
// Reset (synchronous, active high) returns the sequencer to idle and drops
// any text in flight.
`timescale 1ns / 1ps
`default_nettype none

module fixed_to_decimal_ascii #(
   parameter int INT_LIMIT = fdasc_pkg::INT_LIMIT_DEFAULT,
   parameter int MAX_FRAC  = fdasc_pkg::MAX_FRAC_DEFAULT,
   parameter int FRAC_BITS = fdasc_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire fdasc_pkg::in_type req_item,
   output logic                   busy,
   output logic                   rsp_strobe,
   output fdasc_pkg::out_type     rsp_item
);

   fdasc_pkg::ctrl_type  ctrl;
   fdasc_pkg::flags_type flags;

   logic                                accept;
   logic                                neg_ff, neg_in;
   logic [fdasc_pkg::INT_W-1:0]         ipart_ff, ipart_in;
   logic [FRAC_BITS-1:0]                fpart_ff, fpart_in;
   logic [2:0]                          frac_cnt_ff, frac_cnt_in;
   logic [2:0]                          k_ff, k_in;
   logic                                started_ff, started_in;
   logic [3:0]                          len_ff, len_in;
   logic                                rsp_strobe_ff, rsp_strobe_in;
   fdasc_pkg::out_type                  rsp_item_ff, rsp_item_in;

   logic [31:0]                         mag;
   logic [31:0]                         ipart_full;
   logic                                sat;
   logic [3:0]                          int_digit;
   logic [fdasc_pkg::POW_W-1:0]         int_sub;
   logic [FRAC_BITS+3:0]                frac_prod;
   logic                                emit;
   logic                                last;
   logic [7:0]                          ch;

   assign accept = start && !busy;

   assign flags.accept    = accept;
   assign flags.int_more  = (k_ff != 3'd0);
   assign flags.frac_zero = (frac_cnt_ff == 3'd0);
   assign flags.frac_more = (frac_cnt_ff > 3'd1);

   fdasc_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl),
      .busy  (busy)
   );

   always_comb begin
      mag        = req_item.value_fixed[31] ? 32'(32'd0 - req_item.value_fixed) :
                                              req_item.value_fixed;
      ipart_full = mag >> FRAC_BITS;
      sat        = ipart_full >= 32'(INT_LIMIT);
   end

   // integer digit at the current power of ten: highest multiple not above
   always_comb begin
      int_digit = 4'd0;
      int_sub   = '0;
      for (int m = 1; m <= 9; m++) begin
         if ({2'b00, ipart_ff} >= fdasc_pkg::POW_W'(m) * fdasc_pkg::pow10(k_ff)) begin
            int_digit = 4'(m);
            int_sub   = fdasc_pkg::POW_W'(m) * fdasc_pkg::pow10(k_ff);
         end
      end
   end

   assign frac_prod = {1'b0, fpart_ff, 3'b000} + {3'b000, fpart_ff, 1'b0};

   always_comb begin
      neg_in      = neg_ff;
      ipart_in    = ipart_ff;
      fpart_in    = fpart_ff;
      frac_cnt_in = frac_cnt_ff;
      k_in        = k_ff;
      started_in  = started_ff;
      len_in      = len_ff;
      emit        = 1'b0;
      last        = 1'b0;
      ch          = fdasc_pkg::CH_ZERO;

      case (ctrl.op)
         fdasc_pkg::OP_NOP: begin
            if (accept) begin
               neg_in      = req_item.value_fixed[31];
               ipart_in    = sat ? fdasc_pkg::INT_W'(INT_LIMIT) :
                                   ipart_full[fdasc_pkg::INT_W-1:0];
               fpart_in    = sat ? '0 : mag[FRAC_BITS-1:0];
               frac_cnt_in = (req_item.frac_digits > 3'(MAX_FRAC)) ? 3'(MAX_FRAC) :
                                                                     req_item.frac_digits;
               k_in        = 3'(fdasc_pkg::TOP_POWER);
               started_in  = 1'b0;
               len_in      = 4'd0;
            end
         end
         fdasc_pkg::OP_SIGN: begin
            emit = neg_ff;
            ch   = fdasc_pkg::CH_MINUS;
         end
         fdasc_pkg::OP_INT: begin
            emit       = (int_digit != 4'd0) || started_ff || (k_ff == 3'd0);
            last       = (k_ff == 3'd0) && (frac_cnt_ff == 3'd0);
            ch         = fdasc_pkg::CH_ZERO + {4'd0, int_digit};
            started_in = emit;
            ipart_in   = fdasc_pkg::INT_W'({2'b00, ipart_ff} - int_sub);
            k_in       = (k_ff != 3'd0) ? k_ff - 3'd1 : k_ff;
         end
         fdasc_pkg::OP_POINT: begin
            emit = (frac_cnt_ff != 3'd0);
            ch   = fdasc_pkg::CH_POINT;
         end
         fdasc_pkg::OP_FRAC: begin
            emit        = 1'b1;
            last        = (frac_cnt_ff == 3'd1);
            ch          = fdasc_pkg::CH_ZERO + {4'd0, frac_prod[FRAC_BITS+3:FRAC_BITS]};
            fpart_in    = frac_prod[FRAC_BITS-1:0];
            frac_cnt_in = frac_cnt_ff - 3'd1;
         end
         default: begin
            emit = 1'b0;
         end
      endcase

      if (emit) begin
         len_in = len_ff + 4'd1;
      end
      rsp_strobe_in           = emit;
      rsp_item_in.char_code   = ch;
      rsp_item_in.last_char   = last;
      rsp_item_in.text_length = last ? len_ff + 4'd1 : 4'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      ipart_ff    <= ipart_in;
      fpart_ff    <= fpart_in;
      frac_cnt_ff <= frac_cnt_in;
      k_ff        <= k_in;
      started_ff  <= started_in;
      len_ff      <= len_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted item did not make the block busy");
   a_last_len: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.last_char |-> rsp_item.text_length != 4'd0)
      else $error("final character without a length");
   a_mid_len: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last_char |-> rsp_item.text_length == 4'd0)
      else $error("length shown before the final character");
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.char_code == fdasc_pkg::CH_MINUS |-> !rsp_item.last_char)
      else $error("text ended on a minus sign");

endmodule

`default_nettype wire
